// File: rtl/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types and constants for the RRIP page replacement block.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int unsigned PAGE_W  = 12;             // page number bits
  localparam int unsigned PAGES   = 1 << PAGE_W;    // pages in the store
  localparam int unsigned LINK_W  = PAGE_W + 1;     // link with nil flag on top
  localparam int unsigned VAL_W   = 2;              // prediction value bits
  localparam int unsigned GROUPS  = 1 << VAL_W;     // one list per value
  localparam int unsigned CNT_W   = PAGE_W + 1;     // list length counter

  localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGES);

  // result codes
  typedef enum logic [1:0] {
    ST_NEW    = 2'd0,
    ST_HIT    = 2'd1,
    ST_VICTIM = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  // request codes
  localparam logic FN_ACCESS = 1'b0;
  localparam logic FN_EVICT  = 1'b1;

  // one page entry in the page memory
  typedef struct packed {
    logic              present;
    logic [VAL_W-1:0]  slot;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // page memory request
  typedef struct packed {
    logic              en;
    logic              we;
    logic [PAGE_W-1:0] addr;
    entry_t            wdata;
  } ram_req_t;

endpackage

// File: rtl/rpr_ram.sv
// ----------------------------------------------------------------------------
// rpr_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rpr_ctrl.sv
// ----------------------------------------------------------------------------
// rpr_ctrl
// Sequencer: list tables, aging offset and page memory read-modify-write.
// ----------------------------------------------------------------------------
module rpr_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [rpr_pkg::PAGE_W-1:0]   page_i,
  input  logic [rpr_pkg::VAL_W-1:0]    insert_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [rpr_pkg::PAGE_W-1:0]   victim_page_o,
  output rpr_pkg::ram_req_t            ram_req_o,
  input  rpr_pkg::entry_t              ram_rdata_i
);

  typedef enum logic [13:0] {
    S_CLR  = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_AGE  = 14'b00000000000100,
    S_RDP  = 14'b00000000001000,
    S_DEC  = 14'b00000000010000,
    S_UNP  = 14'b00000000100000,
    S_UNPW = 14'b00000001000000,
    S_UNN  = 14'b00000010000000,
    S_UNNW = 14'b00000100000000,
    S_LINK = 14'b00001000000000,
    S_LNKR = 14'b00010000000000,
    S_LNKW = 14'b00100000000000,
    S_FREE = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_e;

  state_e                            state_q, state_d;
  logic [rpr_pkg::PAGE_W-1:0]        clr_q, clr_d;
  logic                              func_q, func_d;
  logic [rpr_pkg::PAGE_W-1:0]        page_q, page_d;
  rpr_pkg::entry_t                   ent_q, ent_d;
  logic [rpr_pkg::VAL_W-1:0]         slot_q, slot_d;
  logic [rpr_pkg::VAL_W-1:0]         offset_q, offset_d;
  logic [rpr_pkg::LINK_W-1:0]        h_q, h_d;
  rpr_pkg::status_e                  res_st_q, res_st_d;
  logic [rpr_pkg::PAGE_W-1:0]        res_vic_q, res_vic_d;
  logic                              out_valid_q, out_valid_d;
  logic [1:0]                        out_st_q, out_st_d;
  logic [rpr_pkg::PAGE_W-1:0]        out_vic_q, out_vic_d;
  logic [rpr_pkg::LINK_W-1:0]        head_q [rpr_pkg::GROUPS];
  logic [rpr_pkg::LINK_W-1:0]        head_d [rpr_pkg::GROUPS];
  logic [rpr_pkg::LINK_W-1:0]        tail_q [rpr_pkg::GROUPS];
  logic [rpr_pkg::LINK_W-1:0]        tail_d [rpr_pkg::GROUPS];
  logic [rpr_pkg::CNT_W-1:0]         count_q [rpr_pkg::GROUPS];
  logic [rpr_pkg::CNT_W-1:0]         count_d [rpr_pkg::GROUPS];

  logic                              any_page;
  logic [rpr_pkg::VAL_W-1:0]         top_slot;
  logic [rpr_pkg::VAL_W-1:0]         dec_val;
  rpr_pkg::entry_t                   wr_ent;

  // a list's value is its slot plus the aging offset
  always_comb begin
    any_page = 1'b0;
    for (int g = 0; g < int'(rpr_pkg::GROUPS); g++) begin
      any_page = any_page | (count_q[g] != '0);
    end
  end

  assign top_slot = rpr_pkg::VAL_W'(rpr_pkg::GROUPS - 1) - offset_q;
  assign dec_val  = rpr_pkg::VAL_W'(ram_rdata_i.slot + offset_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    page_d      = page_q;
    ent_d       = ent_q;
    slot_d      = slot_q;
    offset_d    = offset_q;
    h_d         = h_q;
    res_st_d    = res_st_q;
    res_vic_d   = res_vic_q;
    out_st_d    = out_st_q;
    out_vic_d   = out_vic_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ram_req_o   = '0;
    wr_ent      = ram_rdata_i;

    unique case (state_q)
      // sweep the page memory after reset
      S_CLR: begin
        ram_req_o.en   = 1'b1;
        ram_req_o.we   = 1'b1;
        ram_req_o.addr = clr_q;
        clr_d          = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          page_d    = page_i;
          res_vic_d = '0;
          state_d   = (func_i == rpr_pkg::FN_EVICT) ? S_AGE : S_RDP;
        end
      end
      // age one step a cycle until the top list holds a page, or report none when all lists are empty
      S_AGE: begin
        if (!any_page) begin
          res_st_d = rpr_pkg::ST_NONE;
          state_d  = S_DONE;
        end else if (count_q[top_slot] == '0) begin
          offset_d = offset_q + 1'b1;
        end else begin
          page_d  = tail_q[top_slot][rpr_pkg::PAGE_W-1:0];
          state_d = S_RDP;
        end
      end
      S_RDP: begin
        ram_req_o.en   = 1'b1;
        ram_req_o.addr = page_q;
        state_d        = S_DEC;
      end
      S_DEC: begin
        ent_d = ram_rdata_i;
        if (func_q == rpr_pkg::FN_EVICT) begin
          slot_d  = ram_rdata_i.slot;
          state_d = S_UNP;
        end else if (!ram_rdata_i.present) begin
          slot_d  = insert_value_i - offset_q;
          state_d = S_LINK;
        end else if (dec_val == '0) begin
          res_st_d = rpr_pkg::ST_HIT;
          state_d  = S_DONE;
        end else begin
          slot_d  = ram_rdata_i.slot;
          state_d = S_UNP;
        end
      end
      // unlink: fix predecessor
      S_UNP: begin
        if (ent_q.prev[rpr_pkg::PAGE_W]) begin
          head_d[slot_q] = ent_q.next;
          state_d        = S_UNN;
        end else begin
          ram_req_o.en   = 1'b1;
          ram_req_o.addr = ent_q.prev[rpr_pkg::PAGE_W-1:0];
          state_d        = S_UNPW;
        end
      end
      S_UNPW: begin
        wr_ent.next     = ent_q.next;
        ram_req_o.en    = 1'b1;
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = ent_q.prev[rpr_pkg::PAGE_W-1:0];
        ram_req_o.wdata = wr_ent;
        state_d         = S_UNN;
      end
      // unlink: fix successor
      S_UNN: begin
        if (ent_q.next[rpr_pkg::PAGE_W]) begin
          tail_d[slot_q]  = ent_q.prev;
          count_d[slot_q] = count_q[slot_q] - 1'b1;
          slot_d          = slot_q - 1'b1;
          state_d         = (func_q == rpr_pkg::FN_EVICT) ? S_FREE : S_LINK;
        end else begin
          ram_req_o.en   = 1'b1;
          ram_req_o.addr = ent_q.next[rpr_pkg::PAGE_W-1:0];
          state_d        = S_UNNW;
        end
      end
      S_UNNW: begin
        wr_ent.prev     = ent_q.prev;
        ram_req_o.en    = 1'b1;
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = ent_q.next[rpr_pkg::PAGE_W-1:0];
        ram_req_o.wdata = wr_ent;
        count_d[slot_q] = count_q[slot_q] - 1'b1;
        slot_d          = slot_q - 1'b1;
        state_d         = (func_q == rpr_pkg::FN_EVICT) ? S_FREE : S_LINK;
      end
      // link page at the head of its list
      S_LINK: begin
        wr_ent.present  = 1'b1;
        wr_ent.slot     = slot_q;
        wr_ent.next     = head_q[slot_q];
        wr_ent.prev     = rpr_pkg::NIL;
        ram_req_o.en    = 1'b1;
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = page_q;
        ram_req_o.wdata = wr_ent;
        h_d             = head_q[slot_q];
        head_d[slot_q]  = {1'b0, page_q};
        count_d[slot_q] = count_q[slot_q] + 1'b1;
        res_st_d        = ent_q.present ? rpr_pkg::ST_HIT : rpr_pkg::ST_NEW;
        if (head_q[slot_q][rpr_pkg::PAGE_W]) begin
          tail_d[slot_q] = {1'b0, page_q};
          state_d        = S_DONE;
        end else begin
          state_d = S_LNKR;
        end
      end
      S_LNKR: begin
        ram_req_o.en   = 1'b1;
        ram_req_o.addr = h_q[rpr_pkg::PAGE_W-1:0];
        state_d        = S_LNKW;
      end
      S_LNKW: begin
        wr_ent.prev     = {1'b0, page_q};
        ram_req_o.en    = 1'b1;
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = h_q[rpr_pkg::PAGE_W-1:0];
        ram_req_o.wdata = wr_ent;
        state_d         = S_DONE;
      end
      // mark the victim absent
      S_FREE: begin
        ram_req_o.en    = 1'b1;
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = page_q;
        ram_req_o.wdata = '0;
        res_st_d        = rpr_pkg::ST_VICTIM;
        res_vic_d       = page_q;
        state_d         = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_vic_d   = res_vic_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
      for (int g = 0; g < int'(rpr_pkg::GROUPS); g++) begin
        head_q[g]  <= rpr_pkg::NIL;
        tail_q[g]  <= rpr_pkg::NIL;
        count_q[g] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    page_q    <= page_d;
    ent_q     <= ent_d;
    slot_q    <= slot_d;
    h_q       <= h_d;
    res_st_q  <= res_st_d;
    res_vic_q <= res_vic_d;
    out_st_q  <= out_st_d;
    out_vic_q <= out_vic_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign victim_page_o = out_vic_q;

endmodule

// File: rtl/rrip_page_replacement.sv
// ----------------------------------------------------------------------------
// rrip_page_replacement
// RRIP page replacement: per-value page lists with aging and victim selection.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry page memory before it takes
// the first item; register writes are taken meanwhile. Items are handled one
// at a time through a single-port page memory, one access per cycle. An
// access to a page at value zero reports a hit; one to an absent page links
// it at the head of its list; a promotion unlinks the page and links it one
// value lower; a victim request reports none when the store is empty, else
// ages the lists (at most three steps) until the top list holds a page and
// frees the tail of that list. The block takes the next item in the cycle
// after the result is handed on; a stalled output holds it in its last step
// until the output register is free. Aging costs no memory walk: each list
// keeps a slot, and its value is the slot plus a global aging offset. A
// finished result waits in an output register while the next item is taken.
module rrip_page_replacement (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [rpr_pkg::PAGE_W-1:0] page_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [rpr_pkg::PAGE_W-1:0] victim_page_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [2:0] ADDR_INSERT = 3'd0;

  logic [rpr_pkg::VAL_W-1:0] insert_value_q;
  rpr_pkg::ram_req_t         ram_req;
  logic [rpr_pkg::ENTRY_W-1:0] ram_rdata;

  // register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insert_value_q <= rpr_pkg::VAL_W'(2);
    end else if (psel && penable && pwrite && (paddr == ADDR_INSERT)) begin
      insert_value_q <= pwdata[rpr_pkg::VAL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_INSERT) ? {{(32 - rpr_pkg::VAL_W){1'b0}}, insert_value_q}
                                         : 32'd0;

  rpr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .page_i         (page_i),
    .insert_value_i (insert_value_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .victim_page_o  (victim_page_o),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (rpr_pkg::entry_t'(ram_rdata))
  );

  rpr_ram #(
    .WIDTH (rpr_pkg::ENTRY_W),
    .DEPTH (rpr_pkg::PAGES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  // victim page is zero unless a victim is returned
  a_vic_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != rpr_pkg::ST_VICTIM)) |-> (victim_page_o == '0))
    else $error("victim page set on a non-victim result");

  // a new result never appears in the cycle right after an accept
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> !out_valid_o)
    else $error("result delivered without processing");

endmodule

// File: tb/rpr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpr_checker
// Watches the request, result and register ports of the RRIP page replacement
// block. It keeps its own copy of the per-value page lists and the insert
// value, predicts each result and compares it with the block's output.
// ----------------------------------------------------------------------------
module rpr_checker
  import rpr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              func_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [1:0]        status_i,
  input  logic [PAGE_W-1:0] victim_page_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic              pready_i,
  output int                fail_cnt_o,
  output int                pending_o
);

  localparam logic [2:0]  ABSENT_VAL  = 3'(GROUPS);
  localparam logic [2:0]  ADDR_INSERT = 3'd0;
  localparam int unsigned TOP         = GROUPS - 1;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] victim;
  } result_t;

  // shadow copy of the page lists
  logic [2:0]        val_q  [PAGES];
  logic [LINK_W-1:0] next_q [PAGES];
  logic [LINK_W-1:0] prev_q [PAGES];
  logic [LINK_W-1:0] head_q [GROUPS];
  logic [LINK_W-1:0] tail_q [GROUPS];
  int unsigned       cnt_q  [GROUPS];
  logic [VAL_W-1:0]  ins_val_q;

  result_t expected_q[$];

  function automatic void push_front(int unsigned p, int unsigned g);
    logic [LINK_W-1:0] h;
    h = head_q[g];
    next_q[p] = h;
    prev_q[p] = NIL;
    if (h != NIL) prev_q[h[PAGE_W-1:0]] = LINK_W'(p);
    else tail_q[g] = LINK_W'(p);
    head_q[g] = LINK_W'(p);
    cnt_q[g]++;
    val_q[p] = 3'(g);
  endfunction

  function automatic void drop_page(int unsigned p, int unsigned g);
    logic [LINK_W-1:0] pv, nx;
    pv = prev_q[p];
    nx = next_q[p];
    if (pv != NIL) next_q[pv[PAGE_W-1:0]] = nx;
    else head_q[g] = nx;
    if (nx != NIL) prev_q[nx[PAGE_W-1:0]] = pv;
    else tail_q[g] = pv;
    if (cnt_q[g] > 0) cnt_q[g]--;
  endfunction

  // shift every list up one value; returns whether any page moved
  function automatic bit age_lists();
    bit moved;
    logic [LINK_W-1:0] p;
    int steps;
    moved = 0;
    for (int g = TOP; g > 0; g--) begin
      if (cnt_q[g-1] != 0) moved = 1;
      head_q[g] = head_q[g-1];
      tail_q[g] = tail_q[g-1];
      cnt_q[g]  = cnt_q[g-1];
      head_q[g-1] = NIL;
      tail_q[g-1] = NIL;
      cnt_q[g-1]  = 0;
      p = head_q[g];
      steps = 0;
      while (p != NIL && steps < PAGES) begin
        val_q[p[PAGE_W-1:0]] = 3'(g);
        p = next_q[p[PAGE_W-1:0]];
        steps++;
      end
    end
    return moved;
  endfunction

  function automatic result_t predict_replacement(logic fn, logic [PAGE_W-1:0] pg);
    result_t r;
    logic [2:0] v;
    logic [LINK_W-1:0] vic;
    r.status = ST_NEW;
    r.victim = '0;
    if (fn == FN_ACCESS) begin
      v = val_q[pg];
      if (v == ABSENT_VAL) begin
        push_front(pg, ins_val_q);
        r.status = ST_NEW;
      end else begin
        if (v != 0) begin
          drop_page(pg, v);
          push_front(pg, v - 1);
        end
        r.status = ST_HIT;
      end
      return r;
    end
    for (int t = 0; cnt_q[TOP] == 0 && t <= GROUPS; t++) begin
      if (!age_lists()) begin
        r.status = ST_NONE;
        return r;
      end
    end
    vic = tail_q[TOP];
    if (cnt_q[TOP] == 0 || vic == NIL) begin
      r.status = ST_NONE;
      return r;
    end
    drop_page(vic[PAGE_W-1:0], TOP);
    val_q[vic[PAGE_W-1:0]] = ABSENT_VAL;
    r.status = ST_VICTIM;
    r.victim = vic[PAGE_W-1:0];
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < PAGES; i++) begin
        val_q[i]  = ABSENT_VAL;
        next_q[i] = '0;
        prev_q[i] = '0;
      end
      for (int g = 0; g < GROUPS; g++) begin
        head_q[g] = NIL;
        tail_q[g] = NIL;
        cnt_q[g]  = 0;
      end
      ins_val_q = 2'd2;
      expected_q.delete();
      fail_cnt_o = 0;
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_INSERT)
        ins_val_q = pwdata_i[VAL_W-1:0];
      // result beat: compare with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status %0d victim %0d",
                   $time, status_i, victim_page_i);
          fail_cnt_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (status_i !== exp_r.status) begin
            $display("%0t: status mismatch exp %0d act %0d", $time, exp_r.status, status_i);
            fail_cnt_o++;
          end
          if (victim_page_i !== exp_r.victim) begin
            $display("%0t: victim_page mismatch exp %0d act %0d",
                     $time, exp_r.victim, victim_page_i);
            fail_cnt_o++;
          end
        end
      end
      // request beat
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_replacement(func_i, page_i));
    end
  end

endmodule

// File: tb/tb_rrip_page_replacement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rrip_page_replacement
// Drives directed and random page accesses and victim requests into the RRIP
// page replacement block under several insert values, with random gaps and
// output stalls; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rrip_page_replacement;
  import rpr_pkg::*;

  localparam int          IDLE_LIMIT  = 20000;  // covers the memory sweep
  localparam int          POOL_SIZE   = 40;
  localparam int          PHASE_ITEMS = 225;
  localparam logic [2:0]  ADDR_INSERT = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED = 3'd4;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              func_i = FN_ACCESS;
  logic [PAGE_W-1:0] page_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        status_o;
  logic [PAGE_W-1:0] victim_page_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                fail_cnt;
  int                pending;
  bit                calm = 1'b0;     // no gaps and no stalls while set
  int                idle_cycles = 0;
  logic [PAGE_W-1:0] pool [POOL_SIZE];

  always #2 clk_i = ~clk_i;

  rrip_page_replacement dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .page_i,
    .out_valid_o, .out_ready_i, .status_o, .victim_page_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rpr_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .func_i, .page_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .victim_page_i(victim_page_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 22);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_req(logic fn, logic [PAGE_W-1:0] pg);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    page_i     <= pg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly accesses over a small page set so hits and aging happen
  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = PAGE_W'($urandom_range(PAGES - 1));
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 60);
      r = $urandom_range(99);
      if (r < 20) send_req(FN_EVICT, PAGE_W'($urandom_range(PAGES - 1)));
      else if (r < 25) send_req(FN_ACCESS, PAGE_W'($urandom_range(PAGES - 1)));
      else send_req(FN_ACCESS, pool[$urandom_range(POOL_SIZE - 1)]);
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, field extremes, promotion down to zero, eviction
    send_req(FN_EVICT, 12'hFFF);
    send_req(FN_ACCESS, 12'h000);
    send_req(FN_ACCESS, 12'hFFF);
    send_req(FN_ACCESS, 12'h000);
    send_req(FN_ACCESS, 12'h000);
    send_req(FN_ACCESS, 12'h000);
    send_req(FN_ACCESS, 12'hA5A);
    send_req(FN_EVICT, 12'h000);
    send_req(FN_EVICT, 12'h000);
    send_req(FN_EVICT, 12'h000);
    send_req(FN_EVICT, 12'h000);
    drain();
    // insert at the top value, then at zero, plus a write to an unused address
    reg_write(ADDR_INSERT, 32'd3);
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    send_req(FN_ACCESS, 12'h555);
    send_req(FN_ACCESS, 12'hAAA);
    send_req(FN_EVICT, 12'h000);
    drain();
    reg_write(ADDR_INSERT, 32'd0);
    send_req(FN_ACCESS, 12'h123);
    send_req(FN_ACCESS, 12'h123);
    send_req(FN_EVICT, 12'h000);
    send_req(FN_EVICT, 12'h000);
    send_req(FN_EVICT, 12'h000);
    drain();

    // random phases under each insert value
    reg_write(ADDR_INSERT, 32'd2);
    random_phase(PHASE_ITEMS);
    reg_write(ADDR_INSERT, 32'd0);
    random_phase(PHASE_ITEMS);
    reg_write(ADDR_INSERT, 32'd3);
    random_phase(PHASE_ITEMS);
    reg_write(ADDR_INSERT, 32'd1);
    random_phase(PHASE_ITEMS);

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rpr_pkg.sv
rtl/rpr_ram.sv
rtl/rpr_ctrl.sv
rtl/rrip_page_replacement.sv
tb/rpr_checker.sv
tb/tb_rrip_page_replacement.sv
